>>> design/fxa_pkg.sv
// Shared types, operation codes and constants for the Q24.8 fixed-point ALU.
package fxa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int W         = 32;
  localparam int QW        = W + FRAC_BITS;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_COMPARE  = 4'd4,
    OP_MIN      = 4'd5,
    OP_MAX      = 4'd6,
    OP_INC      = 4'd7,
    OP_DEC      = 4'd8,
    OP_TO_INT   = 4'd9,
    OP_FROM_INT = 4'd10
  } op_t;

  typedef struct packed {
    logic [3:0]          operation;
    logic signed [W-1:0] operand_a;
    logic signed [W-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [W-1:0] result_value;
    logic                is_less;
    logic                is_equal;
    logic                is_greater;
    logic                divide_by_zero;
  } rsp_t;

  // Everything an item carries besides the divider datapath.
  typedef struct packed {
    rsp_t rsp;
    logic use_div;
  } side_t;

endpackage

>>> design/fixed_point_q24_8_alu_core.sv
// Top level of the signed Q24.8 fixed-point ALU pipeline.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one item: operation code and
//   two raw Q24.8 operands. rsp channel (rsp_valid/rsp_ready/rsp) returns one
//   item per request: raw result and less/equal/greater/divide-by-zero flags.
//   Items leave in the order they entered.
// Stages: from acceptance to rsp_valid an item passes three front stages
//   (operand decode, 32x32 multiply, product rounding), one divider stage per
//   quotient bit (32 + FRAC_BITS), and the quotient rounding stage that is
//   also the output register.
// Throughput: one item per cycle while the output is not stalled; every operation takes the same path length.
// Stall: the whole pipeline holds while rsp_valid is high and rsp_ready is
//   low; req_ready is low exactly then. Bubbles do not compress under stall.
// Reset: synchronous rst clears all valid bits; no item is in flight after it.
module fixed_point_q24_8_alu_core import fxa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic adv;
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  // Stage 1: decode, compare, simple operations, magnitudes.
  logic [W-1:0] mag_a_c, mag_b_c, to_int_mag;
  logic         neg_a_c, neg_b_c;
  side_t        side1_c;

  always_comb begin
    neg_a_c    = req.operand_a[W-1];
    neg_b_c    = req.operand_b[W-1];
    mag_a_c    = neg_a_c ? -req.operand_a : req.operand_a;
    mag_b_c    = neg_b_c ? -req.operand_b : req.operand_b;
    to_int_mag = mag_a_c >> FRAC_BITS;

    side1_c                    = '0;
    side1_c.rsp.is_less        = req.operand_a < req.operand_b;
    side1_c.rsp.is_equal       = req.operand_a == req.operand_b;
    side1_c.rsp.is_greater     = req.operand_a > req.operand_b;
    case (req.operation)
      OP_ADD:      side1_c.rsp.result_value = req.operand_a + req.operand_b;
      OP_SUB:      side1_c.rsp.result_value = req.operand_a - req.operand_b;
      OP_DIV: begin
        if (req.operand_b == '0) begin
          side1_c.rsp.divide_by_zero = 1'b1;
        end else begin
          side1_c.use_div = 1'b1;
        end
      end
      OP_MIN: side1_c.rsp.result_value =
          (req.operand_b < req.operand_a) ? req.operand_b : req.operand_a;
      OP_MAX: side1_c.rsp.result_value =
          (req.operand_b > req.operand_a) ? req.operand_b : req.operand_a;
      OP_INC:      side1_c.rsp.result_value = req.operand_a + W'(1);
      OP_DEC:      side1_c.rsp.result_value = req.operand_a - W'(1);
      OP_TO_INT:   side1_c.rsp.result_value = neg_a_c ? -to_int_mag : to_int_mag;
      OP_FROM_INT: side1_c.rsp.result_value = req.operand_a <<< FRAC_BITS;
      default:     side1_c.rsp.result_value = '0;
    endcase
  end

  logic         v1, v2, v3;
  side_t        side1, side2, side3;
  logic [W-1:0] mag_a1, mag_b1, mag_a2, mag_b2, mag_a3, mag_b3;
  logic         neg1, neg2, neg3;
  logic         mul1, mul2;
  logic [2*W-1:0] prod2;

  // Advance valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Product rounding: add half an LSB, drop fraction bits, restore the sign.
  logic [2*W-1:0] prod_rnd;
  logic [W-1:0]   prod_mag;
  side_t          side3_c;

  always_comb begin
    prod_rnd = (prod2 + (2*W)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    prod_mag = prod_rnd[W-1:0];
    side3_c  = side2;
    if (mul2) begin
      side3_c.rsp.result_value = neg2 ? -prod_mag : prod_mag;
    end
  end

  // Advance front datapath.
  always_ff @(posedge clk) begin
    if (adv) begin
      side1  <= side1_c;
      mag_a1 <= mag_a_c;
      mag_b1 <= mag_b_c;
      neg1   <= neg_a_c ^ neg_b_c;
      mul1   <= req.operation == OP_MUL;

      side2  <= side1;
      mag_a2 <= mag_a1;
      mag_b2 <= mag_b1;
      neg2   <= neg1;
      mul2   <= mul1;
      prod2  <= mag_a1 * mag_b1;

      side3  <= side3_c;
      mag_a3 <= mag_a2;
      mag_b3 <= mag_b2;
      neg3   <= neg2;
    end
  end

  fxa_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v3),
    .num_in    (mag_a3),
    .den_in    (mag_b3),
    .neg_in    (neg3),
    .side_in   (side3),
    .out_valid (rsp_valid),
    .out       (rsp)
  );

  // Exactly one ordering flag on every item.
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot({rsp.is_less, rsp.is_equal, rsp.is_greater}))
    else $error("ordering flags not one-hot");

  // A zero divisor yields a zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_by_zero |-> rsp.result_value == '0)
    else $error("divide by zero with nonzero result");

  // Pipeline moves only when the output is free or taken.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("req_ready out of step with output stall");

  // No item survives reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid high after reset");

endmodule

>>> design/fxa_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding stage.
module fxa_divider import fxa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] num_in,
  input  logic [W-1:0] den_in,
  input  logic         neg_in,
  input  side_t        side_in,
  output logic         out_valid,
  output rsp_t         out
);

  logic [QW-1:0] vld;
  logic [QW-1:0] quo  [QW];
  logic [W-1:0]  rem  [QW];
  logic [W-1:0]  den  [QW];
  logic          neg  [QW];
  side_t         side [QW];

  logic [QW-1:0] quo_next [QW];
  logic [W-1:0]  rem_next [QW];

  // Shift one numerator bit into the remainder and try to subtract.
  always_comb begin
    logic [W:0]    t;
    logic [QW-1:0] qs;
    logic [W-1:0]  rs;
    logic [W-1:0]  ds;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        qs = {num_in, {FRAC_BITS{1'b0}}};
        rs = '0;
        ds = den_in;
      end else begin
        qs = quo[i-1];
        rs = rem[i-1];
        ds = den[i-1];
      end
      t = {rs, qs[QW-1]};
      if (t >= {1'b0, ds}) begin
        rem_next[i] = W'(t - {1'b0, ds});
        quo_next[i] = {qs[QW-2:0], 1'b1};
      end else begin
        rem_next[i] = t[W-1:0];
        quo_next[i] = {qs[QW-2:0], 1'b0};
      end
    end
  end

  // Advance valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  // Advance datapath.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        quo[i] <= quo_next[i];
        rem[i] <= rem_next[i];
        if (i == 0) begin
          den[i]  <= den_in;
          neg[i]  <= neg_in;
          side[i] <= side_in;
        end else begin
          den[i]  <= den[i-1];
          neg[i]  <= neg[i-1];
          side[i] <= side[i-1];
        end
      end
    end
  end

  // Round half away from zero: bump when twice the remainder reaches the divisor.
  logic         round_up;
  logic [W-1:0] q_mag;
  rsp_t         out_next;

  always_comb begin
    round_up = {rem[QW-1], 1'b0} >= {1'b0, den[QW-1]};
    q_mag    = quo[QW-1][W-1:0] + W'(round_up);
    out_next = side[QW-1].rsp;
    if (side[QW-1].use_div) begin
      out_next.result_value = neg[QW-1] ? -q_mag : q_mag;
    end
  end

  // Hold the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= out_next;
    end
  end

endmodule

>>> test/fixed_point_q24_8_alu_core_test.sv
// Self-checking testbench for the Q24.8 fixed-point ALU core.
`timescale 1ns / 100ps

module fixed_point_q24_8_alu_core_test;
  import fxa_pkg::*;

  localparam int LATENCY     = FRAC_BITS + 36;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  fixed_point_q24_8_alu_core dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Holds the expected ALU results in issue order.
  class alu_scoreboard;
    rsp_t pending[$];

    // Round half away from zero on magnitudes, then reapply the sign.
    function automatic logic [31:0] mul_fixed(logic signed [31:0] a, logic signed [31:0] b);
      logic [63:0] ma, mb, p, r;
      ma = a[31] ? 64'(-64'(signed'(a))) : 64'(a);
      mb = b[31] ? 64'(-64'(signed'(b))) : 64'(b);
      p = ma * mb;
      r = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return (a[31] != b[31]) ? 32'(-r) : 32'(r);
    endfunction

    function automatic logic [31:0] div_fixed(logic signed [31:0] a, logic signed [31:0] b);
      logic [63:0] num, den, q;
      num = (a[31] ? 64'(-64'(signed'(a))) : 64'(a)) << FRAC_BITS;
      den = b[31] ? 64'(-64'(signed'(b))) : 64'(b);
      q = (2 * num + den) / (2 * den);
      return (a[31] != b[31]) ? 32'(-q) : 32'(q);
    endfunction

    // Note an accepted input item and queue its expected result.
    function void note_request(req_t r);
      rsp_t e;
      logic signed [31:0] a, b;
      logic [31:0] mag;
      a = r.operand_a;
      b = r.operand_b;
      e = '0;
      case (r.operation)
        OP_ADD:      e.result_value = a + b;
        OP_SUB:      e.result_value = a - b;
        OP_MUL:      e.result_value = mul_fixed(a, b);
        OP_DIV: begin
          if (b == 0) e.divide_by_zero = 1'b1;
          else e.result_value = div_fixed(a, b);
        end
        OP_COMPARE:  e.result_value = '0;
        OP_MIN:      e.result_value = (b < a) ? b : a;
        OP_MAX:      e.result_value = (b > a) ? b : a;
        OP_INC:      e.result_value = a + 1;
        OP_DEC:      e.result_value = a - 1;
        OP_TO_INT: begin
          mag = a[31] ? 32'(-a) : 32'(a);
          mag = mag >> FRAC_BITS;
          e.result_value = a[31] ? -mag : mag;
        end
        OP_FROM_INT: e.result_value = a <<< FRAC_BITS;
        default:     e.result_value = '0;
      endcase
      e.is_less = a < b;
      e.is_equal = a == b;
      e.is_greater = a > b;
      pending.push_back(e);
    endfunction

    // Compare an accepted result with the oldest expectation.
    task check_result(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected item", got.result_value, '0);
        return;
      end
      e = pending.pop_front();
      if (got.result_value !== e.result_value)
        report_mismatch("result_value", got.result_value, e.result_value);
      if (got.is_less !== e.is_less) report_mismatch("is_less", got.is_less, e.is_less);
      if (got.is_equal !== e.is_equal) report_mismatch("is_equal", got.is_equal, e.is_equal);
      if (got.is_greater !== e.is_greater)
        report_mismatch("is_greater", got.is_greater, e.is_greater);
      if (got.divide_by_zero !== e.divide_by_zero)
        report_mismatch("divide_by_zero", got.divide_by_zero, e.divide_by_zero);
    endtask
  endclass

  alu_scoreboard board = new();

  // Mostly short gaps, occasionally a long one.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Track results and time out.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && rsp_valid && rsp_ready) board.check_result(rsp);
    if (!rst && req_valid && req_ready) board.note_request(req);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fixed_point_q24_8_alu_core verification failed");
      $finish;
    end
  end

  // Random receiver stalls, with calm stretches.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      rsp_ready <= 1'b1;
      n = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
      repeat (n) @(posedge clk);
      n = gap_length();
      if (n > 0) begin
        rsp_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Send one item, holding it until accepted, then optionally idle.
  task automatic send_item(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                           input int gap);
    req_valid <= 1'b1;
    req <= '{operation: op, operand_a: a, operand_b: b};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000 + $urandom_range(0, 2);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      2: return 32'($signed($urandom_range(0, 1024)) - 512);
      3: return 32'($urandom_range(0, 8)) << FRAC_BITS;
      4: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] corner[6];
    int i;
    logic [31:0] a;
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0000_0080,
               32'hFFFF_FF80};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operation on extremes, divide by zero, ties, unused codes.
    for (i = 0; i <= 15; i++)
      send_item(4'(i), corner[i % 6], corner[(i + 1) % 6], 0);
    send_item(OP_DIV, 32'h0000_0300, 32'h0, 0);
    send_item(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_item(OP_MUL, 32'h0000_0180, 32'hFFFF_FF80, 0);
    send_item(OP_MIN, 32'h0000_1234, 32'h0000_1234, 0);
    send_item(OP_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_item(OP_TO_INT, 32'hFFFF_FE80, 32'h0, 0);
    send_item(OP_DIV, 32'h0000_0100, 32'h0000_0300, 0);
    send_item(OP_FROM_INT, 32'h0080_0000, 32'hFFFF_FFFF, 0);

    // Drain once completely before the random part.
    req_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);

    for (i = 0; i < 550; i++) begin
      a = pick_operand();
      send_item(($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(0, 10)),
                a, ($urandom_range(0, 9) == 0) ? a : pick_operand(), gap_length());
    end
    req_valid <= 1'b0;
    @(posedge clk);

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && board.pending.size() == 0)
      $display("fixed_point_q24_8_alu_core verification clean");
    else
      $display("fixed_point_q24_8_alu_core verification failed");
    $finish;
  end

endmodule
